/* rtl/core/awmd_pkg.sv */
`timescale 1ns / 1ps

package awmd_pkg;

  localparam int unsigned LinearFracDef = 16;
  localparam int unsigned QBits         = 30;
  localparam int unsigned FifoDepthDef  = 2;

  // Fixed item fields: divisor is at most 2*4*255, alpha sum at most 4*255.
  localparam int unsigned DenW  = 11;
  localparam int unsigned AsumW = 10;

  // Decode divisors for fractions over 510.
  localparam logic [63:0] LinSegDiv = 64'd1292 * 64'd510;
  localparam logic [63:0] PowSegDiv = 64'd1055 * 64'd510;

  typedef logic [31:0] word_tab_t [256];

  function automatic int unsigned num_width(int unsigned lf);
    return lf + 11;
  endfunction

  function automatic int unsigned item_width(int unsigned lf);
    return 3 * num_width(lf) + DenW + 8 + 1;
  endfunction

  // Restoring division, one quotient bit per step.
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << (QBits - 1))) >> QBits;
  endfunction

  function automatic logic [63:0] pow5q(logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = mulq(y, y);
    y4 = mulq(y2, y2);
    return mulq(y4, y);
  endfunction

  function automatic logic [63:0] root5q(logic [63:0] x);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 64'd0;
    hi = 64'd1 << QBits;
    for (int it = 0; it < 40; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5q(mid) <= x) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB decode of n/510 in Q30; a byte b is decoded as 2b/510.
  function automatic logic [63:0] dec510(logic [63:0] n);
    logic [63:0] t;
    logic [63:0] t2;
    if (100000 * n <= 64'd4045 * 510) begin
      return udiv64((100 * n << QBits) + 64'd646 * 510, LinSegDiv);
    end
    t  = udiv64(((1000 * n + 64'd55 * 510) << QBits) + 64'd269025, PowSegDiv);
    t2 = mulq(t, t);
    return mulq(t2, root5q(t2));
  endfunction

  function automatic word_tab_t build_lin(int unsigned lf);
    word_tab_t   tab;
    logic [63:0] q;
    int unsigned s;
    s = QBits - lf;
    for (int b = 0; b < 256; b++) begin
      q      = dec510(64'(2 * b));
      tab[b] = 32'((q + (64'd1 << (s - 1))) >> s);
    end
    return tab;
  endfunction

  function automatic word_tab_t build_thr();
    word_tab_t tab;
    tab[0] = 32'd0;
    for (int k = 1; k < 256; k++) begin
      tab[k] = 32'(dec510(64'(2 * k - 1)));
    end
    return tab;
  endfunction

  // Encode thresholds in Q30: byte k is chosen once the mean reaches entry k.
  localparam word_tab_t ThrTab = build_thr();

endpackage

/* rtl/core/awmd_quad_if.sv */
`timescale 1ns / 1ps

interface awmd_quad_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_top_left;
  logic [31:0] texel_top_right;
  logic [31:0] texel_bottom_left;
  logic [31:0] texel_bottom_right;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right,
    output ready
  );
endinterface

/* rtl/core/awmd_texel_if.sv */
`timescale 1ns / 1ps

interface awmd_texel_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

/* rtl/core/awmd_front.sv */
`timescale 1ns / 1ps

module awmd_front import awmd_pkg::*; #(
  parameter int unsigned LinearFrac = LinearFracDef,
  parameter int unsigned ItemW      = item_width(LinearFracDef)
) (
  input  logic             srgb_i,
  awmd_quad_if.sink        quad,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output logic [ItemW-1:0] push_data_o
);

  localparam int unsigned VW   = LinearFrac + 1;
  localparam int unsigned NumW = num_width(LinearFrac);
  localparam word_tab_t   LinTab = build_lin(LinearFrac);

  logic [31:0]      tex [4];
  logic [7:0]       alpha [4];
  logic [AsumW-1:0] asum;
  logic [VW-1:0]    lin [3][4];
  logic [NumW-1:0]  num [3];
  logic [NumW-1:0]  plain [3];
  logic [NumW-1:0]  dvd [3];
  logic [DenW-1:0]  den;
  logic [7:0]       aout;

  assign tex[0] = quad.texel_top_left;
  assign tex[1] = quad.texel_top_right;
  assign tex[2] = quad.texel_bottom_left;
  assign tex[3] = quad.texel_bottom_right;

  always_comb begin
    asum = '0;
    for (int i = 0; i < 4; i++) begin
      alpha[i] = tex[i][31:24];
      asum     = asum + AsumW'(alpha[i]);
    end
    for (int c = 0; c < 3; c++) begin
      num[c]   = '0;
      plain[c] = '0;
      for (int i = 0; i < 4; i++) begin
        lin[c][i] = srgb_i ? LinTab[tex[i][8*c +: 8]][VW-1:0] : VW'(tex[i][8*c +: 8]);
        num[c]    = num[c] + NumW'(lin[c][i]) * NumW'(alpha[i]);
        plain[c]  = plain[c] + NumW'(lin[c][i]);
      end
      // Weighted mean rounds as (2*num + asum) / (2*asum); plain mean as (sum + 2) / 4.
      dvd[c] = (asum != '0) ? NumW'({num[c], 1'b0} + NumW'(asum)) : NumW'(plain[c] + 2);
    end
    den  = (asum != '0) ? {asum, 1'b0} : DenW'(4);
    aout = 8'((asum + AsumW'(2)) >> 2);
  end

  assign push_valid_o = quad.valid;
  assign quad.ready   = push_ready_i;
  assign push_data_o  = {srgb_i, aout, den, dvd[2], dvd[1], dvd[0]};

endmodule

/* rtl/core/awmd_fifo.sv */
`timescale 1ns / 1ps

module awmd_fifo import awmd_pkg::*; #(
  parameter int unsigned DataW = item_width(LinearFracDef),
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [DataW-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [DataW-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    cnt_d = CntW'(cnt_q + CntW'(push) - CntW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fifo count beyond depth");
  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == CntW'($past(cnt_q) + 1'b1)))
    else $error("fifo count missed a push");
`endif

endmodule

/* rtl/core/awmd_back.sv */
`timescale 1ns / 1ps

module awmd_back import awmd_pkg::*; #(
  parameter int unsigned LinearFrac = LinearFracDef,
  parameter int unsigned ItemW      = item_width(LinearFracDef)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  logic [ItemW-1:0] pop_data_i,
  awmd_texel_if.source     texel
);

  localparam int unsigned NumW = num_width(LinearFrac);
  localparam int unsigned QW   = LinearFrac + 1;
  localparam int unsigned RemW = DenW;
  localparam int unsigned Sh   = QBits - LinearFrac;

  logic en;

  // Divider stages: one quotient bit per stage.
  logic            dv_vld_q  [QW+1];
  logic            dv_srgb_q [QW+1];
  logic [7:0]      dv_aout_q [QW+1];
  logic [DenW-1:0] dv_den_q  [QW+1];
  logic [RemW-1:0] dv_rem_q  [QW+1][3];
  logic [QW-1:0]   dv_low_q  [QW+1][3];
  logic [RemW-1:0] rem_nx    [QW][3];
  logic [QW-1:0]   low_nx    [QW][3];
  logic [RemW:0]   trial     [QW][3];
  logic            ge        [QW][3];

  // Encode stages: one code bit per stage.
  logic          ec_vld_q  [9];
  logic          ec_srgb_q [9];
  logic [7:0]    ec_aout_q [9];
  logic [QW-1:0] ec_q_q    [9][3];
  logic [7:0]    ec_code_q [9][3];
  logic [7:0]    code_nx   [8][3];
  logic [7:0]    cand      [8][3];
  logic [7:0]    res       [3];

  assign en          = !ec_vld_q[8] || texel.ready;
  assign pop_ready_o = en;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int c = 0; c < 3; c++) begin
        trial[k][c]  = {dv_rem_q[k][c], dv_low_q[k][c][QW-1]};
        ge[k][c]     = (trial[k][c] >= {1'b0, dv_den_q[k]});
        rem_nx[k][c] = ge[k][c] ? RemW'(trial[k][c] - {1'b0, dv_den_q[k]})
                                : trial[k][c][RemW-1:0];
        low_nx[k][c] = {dv_low_q[k][c][QW-2:0], ge[k][c]};
      end
    end
    for (int j = 0; j < 8; j++) begin
      for (int c = 0; c < 3; c++) begin
        cand[j][c]    = ec_code_q[j][c] | (8'h80 >> j);
        code_nx[j][c] = (ThrTab[cand[j][c]][QBits:0] <= {ec_q_q[j][c], {Sh{1'b0}}})
                        ? cand[j][c] : ec_code_q[j][c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (ec_srgb_q[8]) res[c] = ec_code_q[8][c];
      else res[c] = (ec_q_q[8][c] > QW'(255)) ? 8'hFF : ec_q_q[8][c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) dv_vld_q[k] <= 1'b0;
      for (int j = 0; j < 9; j++)   ec_vld_q[j] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= pop_valid_i;
      for (int k = 0; k < QW; k++) dv_vld_q[k+1] <= dv_vld_q[k];
      ec_vld_q[0] <= dv_vld_q[QW];
      for (int j = 0; j < 8; j++) ec_vld_q[j+1] <= ec_vld_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_srgb_q[0] <= pop_data_i[3*NumW+DenW+8];
      dv_aout_q[0] <= pop_data_i[3*NumW+DenW +: 8];
      dv_den_q[0]  <= pop_data_i[3*NumW +: DenW];
      for (int c = 0; c < 3; c++) begin
        dv_rem_q[0][c] <= RemW'(pop_data_i[c*NumW+QW +: NumW-QW]);
        dv_low_q[0][c] <= pop_data_i[c*NumW +: QW];
      end
      for (int k = 0; k < QW; k++) begin
        dv_srgb_q[k+1] <= dv_srgb_q[k];
        dv_aout_q[k+1] <= dv_aout_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        for (int c = 0; c < 3; c++) begin
          dv_rem_q[k+1][c] <= rem_nx[k][c];
          dv_low_q[k+1][c] <= low_nx[k][c];
        end
      end
      ec_srgb_q[0] <= dv_srgb_q[QW];
      ec_aout_q[0] <= dv_aout_q[QW];
      for (int c = 0; c < 3; c++) begin
        ec_q_q[0][c]    <= dv_low_q[QW][c];
        ec_code_q[0][c] <= '0;
      end
      for (int j = 0; j < 8; j++) begin
        ec_srgb_q[j+1] <= ec_srgb_q[j];
        ec_aout_q[j+1] <= ec_aout_q[j];
        for (int c = 0; c < 3; c++) begin
          ec_q_q[j+1][c]    <= ec_q_q[j][c];
          ec_code_q[j+1][c] <= code_nx[j][c];
        end
      end
    end
  end

  assign texel.valid     = ec_vld_q[8];
  assign texel.out_red   = res[0];
  assign texel.out_green = res[1];
  assign texel.out_blue  = res[2];
  assign texel.out_alpha = ec_aout_q[8];

`ifndef SYNTHESIS
  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[QW] |-> (dv_rem_q[QW][0] < dv_den_q[QW]) && (dv_rem_q[QW][1] < dv_den_q[QW])
                     && (dv_rem_q[QW][2] < dv_den_q[QW]))
    else $error("divider remainder not below divisor");
  a_linear_fits_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_vld_q[8] && !ec_srgb_q[8]) |-> (ec_q_q[8][0] <= QW'(255))
      && (ec_q_q[8][1] <= QW'(255)) && (ec_q_q[8][2] <= QW'(255)))
    else $error("linear mean above one byte");
`endif

endmodule

/* rtl/core/alpha_weighted_mip_downsample_core.sv */
`timescale 1ns / 1ps

// 2x2 alpha-weighted mip downsample. Each beat on quad_i carries four RGBA8 texels
// (red 7:0 .. alpha 31:24); each beat on texel_o carries one coarser texel. Colour is
// sum(c*a)/sum(a), the plain mean when all alphas are zero; alpha is the rounded mean.
// With srgb_mode set, colour is decoded to linear light (LinearFrac fraction bits),
// averaged and re-encoded. One quad is taken every cycle while the queue has room. Each
// quad's item is loaded from the queue, passes the bit-per-stage divider (LinearFrac + 1
// stages), is loaded into the encoder and passes the eight-stage encode search. A held
// output stalls the back pipeline; the two-entry queue lets the input keep taking beats
// until it fills.
// Write srgb_mode only while no beat is in flight.
module alpha_weighted_mip_downsample_core import awmd_pkg::*; #(
  parameter int unsigned LinearFrac = LinearFracDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  awmd_quad_if.sink     quad_i,
  awmd_texel_if.source  texel_o
);

  localparam int unsigned ItemW = item_width(LinearFrac);

  logic             srgb_q;
  logic             push_valid, push_ready;
  logic [ItemW-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [ItemW-1:0] pop_data;

  // Hold the mode register; user writes only while the block is idle, not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srgb_q <= 1'b0;
    end else if (cfg_we_i) begin
      srgb_q <= cfg_wdata_i;
    end
  end

  // Front: decode texels, form weighted sums and the divisor.
  awmd_front #(
    .LinearFrac (LinearFrac),
    .ItemW      (ItemW)
  ) u_front (
    .srgb_i       (srgb_q),
    .quad         (quad_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue: decouple the front from back-pressure at the output.
  awmd_fifo #(
    .DataW (ItemW),
    .Depth (FifoDepthDef)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  // Back: divide, re-encode (or clamp in linear mode) and present the result beat.
  awmd_back #(
    .LinearFrac (LinearFrac),
    .ItemW      (ItemW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .texel       (texel_o)
  );

endmodule

/* dv/alpha_weighted_mip_downsample_core_test.sv */
`timescale 1ns / 1ps

module alpha_weighted_mip_downsample_core_test;
  import awmd_pkg::*;

  localparam int unsigned LinFrac = LinearFracDef;
  localparam int unsigned Q       = 30;
  // wait bound for a result to follow its quad; callers add a margin on top
  localparam int unsigned Latency = LinFrac + 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  awmd_quad_if  quad ();
  awmd_texel_if texel ();

  alpha_weighted_mip_downsample_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .quad_i      (quad),
    .texel_o     (texel)
  );

  // Predictor state: the mode register and the two lookup tables.
  bit          srgb_on;
  logic [31:0] lin_of_byte [256];   // byte -> linear light, LinFrac fraction bits
  logic [63:0] enc_thr     [256];   // Q30 threshold at which byte k is reached

  texel_t      pending_texels[$];
  int unsigned mismatches;
  int unsigned quads_sent;
  int unsigned texels_seen;
  int unsigned srgb_quads;
  bit          calm;                // no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d texels outstanding", pending_texels.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point sRGB arithmetic, all in Q30 with half-up rounded products.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << (Q - 1))) >> Q;
  endfunction

  function automatic logic [63:0] q_fifth(logic [63:0] y);
    logic [63:0] sq;
    sq = q_mul(y, y);
    return q_mul(q_mul(sq, sq), y);
  endfunction

  // largest y with y^5 <= x
  function automatic logic [63:0] q_fifth_root(logic [63:0] x);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 0;
    hi = 64'd1 << Q;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (q_fifth(mid) <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // decode the encoded fraction n/d to linear light; the power 2.4 is t^2 * t^(2/5)
  function automatic logic [63:0] srgb_decode(logic [63:0] n, logic [63:0] d);
    logic [63:0] t;
    logic [63:0] t2;
    if (100000 * n <= 4045 * d) return ((100 * n << Q) + 646 * d) / (1292 * d);
    t  = (((1000 * n + 55 * d) << Q) + (1055 * d) / 2) / (1055 * d);
    t2 = q_mul(t, t);
    return q_mul(t2, q_fifth_root(t2));
  endfunction

  function automatic void build_tables();
    int unsigned sh;
    sh = Q - LinFrac;
    for (int b = 0; b < 256; b++) begin
      lin_of_byte[b] = 32'((srgb_decode(b, 255) + (64'd1 << (sh - 1))) >> sh);
      enc_thr[b]     = (b == 0) ? 64'd0 : srgb_decode(2 * b - 1, 510);
    end
  endfunction

  function automatic logic [7:0] linear_to_srgb(logic [63:0] l);
    logic [63:0] lq;
    int unsigned k;
    lq = l << (Q - LinFrac);
    k  = 0;
    for (int i = 1; i < 256; i++) if (enc_thr[i] <= lq) k = i;
    return 8'(k);
  endfunction

  function automatic texel_t downsample(logic [31:0] quad_texels [4]);
    texel_t      res;
    logic [63:0] asum;
    logic [63:0] num;
    logic [63:0] plain;
    logic [63:0] v;
    logic [63:0] mean;
    logic [7:0]  chan [3];
    asum = 0;
    for (int i = 0; i < 4; i++) asum += quad_texels[i][31:24];
    for (int c = 0; c < 3; c++) begin
      num   = 0;
      plain = 0;
      for (int i = 0; i < 4; i++) begin
        v      = quad_texels[i][8*c +: 8];
        if (srgb_on) v = lin_of_byte[v];
        num   += v * quad_texels[i][31:24];
        plain += v;
      end
      mean = (asum > 0) ? (2 * num + asum) / (2 * asum) : (plain + 2) / 4;
      if (srgb_on) chan[c] = linear_to_srgb(mean);
      else chan[c] = (mean > 255) ? 8'd255 : 8'(mean);
    end
    res.red   = chan[0];
    res.green = chan[1];
    res.blue  = chan[2];
    res.alpha = 8'((asum + 2) >> 2);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Quad driver: hold the beat until accepted, then log its expected texel.
  // ---------------------------------------------------------------------------
  task automatic send_quad(logic [31:0] tl, logic [31:0] tr, logic [31:0] bl,
                           logic [31:0] br);
    int unsigned gap;
    logic [31:0] q4 [4];
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      @(negedge clk);
      quad.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    quad.valid              = 1'b1;
    quad.texel_top_left     = tl;
    quad.texel_top_right    = tr;
    quad.texel_bottom_left  = bl;
    quad.texel_bottom_right = br;
    @(posedge clk);
    while (!quad.ready) @(posedge clk);
    q4 = '{tl, tr, bl, br};
    pending_texels.push_back(downsample(q4));
    quads_sent++;
    if (srgb_on) srgb_quads++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    quad.valid = 1'b0;
  endtask

  // Drain everything in flight, then write the mode register.
  task automatic set_srgb_mode(bit mode);
    drop_valid();
    while (pending_texels.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we    = 1'b0;
    srgb_on   = mode;
  endtask

  // ---------------------------------------------------------------------------
  // Texel sink: random stall bursts, off once calm is set.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    texel.ready = 1'b0;
    stall       = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        texel.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall       = $urandom_range(0, 13);
        texel.ready = 1'b0;
      end else begin
        texel.ready = 1'b1;
      end
    end
  end

  // Compare each accepted texel with the oldest prediction.
  always @(posedge clk) begin
    texel_t want;
    if (rst_n && texel.valid && texel.ready) begin
      texels_seen++;
      if (pending_texels.size() == 0) begin
        $error("texel with nothing predicted: r=%0d g=%0d b=%0d a=%0d",
               texel.out_red, texel.out_green, texel.out_blue, texel.out_alpha);
        mismatches++;
      end else begin
        want = pending_texels.pop_front();
        if (texel.out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, texel.out_red);
          mismatches++;
        end
        if (texel.out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, texel.out_green);
          mismatches++;
        end
        if (texel.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, texel.out_blue);
          mismatches++;
        end
        if (texel.out_alpha !== want.alpha) begin
          $error("out_alpha: expected %0d, got %0d", want.alpha, texel.out_alpha);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rgba(int r, int g, int b, int a);
    return {8'(a), 8'(b), 8'(g), 8'(r)};
  endfunction

  // Random texel, biased towards the alpha and red extremes.
  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 5))
      0: t[31:24] = 8'd0;
      1: t[31:24] = 8'd255;
      2: t[7:0]   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: ;
    endcase
    return t;
  endfunction

  // Extremes, all-zero alpha fallback, single opaque texel and rounding ties.
  task automatic test_directed_quads();
    send_quad(0, 0, 0, 0);
    send_quad('1, '1, '1, '1);
    send_quad(rgba(255, 0, 128, 0), rgba(0, 255, 1, 0), rgba(3, 3, 3, 0),
              rgba(255, 255, 255, 0));
    send_quad(rgba(200, 10, 90, 255), rgba(0, 0, 0, 0), rgba(255, 255, 255, 0),
              rgba(7, 7, 7, 0));
    send_quad(rgba(255, 255, 255, 1), rgba(0, 0, 0, 255), rgba(0, 0, 0, 255),
              rgba(0, 0, 0, 255));
    send_quad(rgba(1, 2, 0, 1), rgba(0, 0, 1, 1), rgba(0, 0, 0, 0), rgba(0, 1, 0, 0));
    send_quad(rgba(10, 11, 12, 1), rgba(11, 12, 13, 0), rgba(12, 13, 14, 0),
              rgba(13, 14, 15, 1));
    send_quad(rgba(255, 0, 255, 128), rgba(0, 255, 0, 128), rgba(255, 0, 255, 127),
              rgba(0, 255, 0, 127));
    send_quad(rgba(1, 254, 10, 2), rgba(2, 253, 11, 1), rgba(0, 255, 9, 0),
              rgba(3, 252, 12, 0));
    send_quad(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
  endtask

  task automatic test_directed_both_modes();
    test_directed_quads();
    set_srgb_mode(1'b1);
    test_directed_quads();
    set_srgb_mode(1'b0);
  endtask

  // Random quads: each is uniform with a one-in-eight chance, else four independent texels.
  task automatic test_random_quads(int unsigned count);
    logic [31:0] t;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        t = rand_texel();
        send_quad(t, t, t, t);
      end else begin
        send_quad(rand_texel(), rand_texel(), rand_texel(), rand_texel());
      end
    end
  endtask

  task automatic test_random_mode_phases();
    set_srgb_mode(1'b1);
    test_random_quads(200);
    set_srgb_mode(1'b0);
    test_random_quads(200);
    set_srgb_mode(1'b1);
    test_random_quads(150);
    // last stretch at full rate on both sides
    calm = 1'b1;
    test_random_quads(180);
    drop_valid();
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = 1'b0;
    quad.valid              = 1'b0;
    quad.texel_top_left     = '0;
    quad.texel_top_right    = '0;
    quad.texel_bottom_left  = '0;
    quad.texel_bottom_right = '0;
    srgb_on                 = 1'b0;
    calm                    = 1'b0;
    mismatches              = 0;
    quads_sent              = 0;
    texels_seen             = 0;
    srgb_quads              = 0;
    build_tables();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_both_modes();
    test_random_mode_phases();

    // wait out the tail of the pipeline
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("covered %0d quads (%0d in sRGB mode), %0d texels checked",
             quads_sent, srgb_quads, texels_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
